### sv/fgs_pkg.sv
package fgs_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_HASH,
      ST_QUOT,
      ST_REM,
      ST_SCALE,
      ST_SEV,
      ST_ROT,
      ST_READ,
      ST_WAIT,
      ST_MIX,
      ST_SUM,
      ST_OUT
   } state_type;

   localparam logic [2:0] CSR_ENTROPY  = 3'd0;
   localparam logic [2:0] CSR_ROT      = 3'd1;
   localparam logic [2:0] CSR_WET      = 3'd2;
   localparam logic [2:0] CSR_GRAIN    = 3'd3;
   localparam logic [2:0] CSR_SEVSTEP  = 3'd4;
   localparam logic [2:0] CSR_CHANNELS = 3'd5;

   localparam int CSR_DATA_BITS = 20;
   localparam logic [31:0] HASH_SALT = 32'd61;
   localparam logic [13:0] JUMP_RANGE = 14'd10000;
   localparam logic [11:0] ROT_MASK_MIN = 12'd3277;
   // 2^45 / 10000 rounded up, which is also 2^41 / 625; exact for 32-bit operands
   localparam logic [31:0] RECIP_10K = 32'hD1B71759;

   // commands from controller to datapath
   typedef struct packed {
      logic clear_step;   // write zero at the clear pointer
      logic take;         // register the accepted word and update counters
      logic hash;         // start jump computation
      logic quot;         // hash quotient by reciprocal
      logic rem;          // hash remainder
      logic scale;        // remainder times entropy
      logic sev;          // register severity
      logic rot;          // register rot
      logic read;         // decide whether a reload from the store is due
      logic load;         // capture read data into held regs when a reload is due
      logic mix;          // products
      logic sum;          // final sum
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic frozen;
   } status_type;

   function automatic logic [31:0] mixhash(input logic [31:0] s_in);
      logic [31:0] s;
      s = (s_in ^ HASH_SALT) ^ (s_in >> 16);
      s = s + (s << 3);
      s = s ^ (s >> 4);
      return s;
   endfunction

endpackage

### sv/fgs_ram.sv
module fgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/fgs_ctrl.sv
module fgs_ctrl
   import fgs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_HASH;
         ST_HASH:  state_in = status.frozen ? ST_QUOT : ST_OUT;
         ST_QUOT:  state_in = ST_REM;
         ST_REM:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_SEV;
         ST_SEV:   state_in = ST_ROT;
         ST_ROT:   state_in = ST_READ;
         ST_READ:  state_in = ST_WAIT;
         ST_WAIT:  state_in = ST_MIX;
         ST_MIX:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take = req_valid;
         end
         ST_HASH:  cmd.hash = 1'b1;
         ST_QUOT:  cmd.quot = 1'b1;
         ST_REM:   cmd.rem = 1'b1;
         ST_SCALE: cmd.scale = 1'b1;
         ST_SEV:   cmd.sev = 1'b1;
         ST_ROT:   cmd.rot = 1'b1;
         ST_READ:  cmd.read = 1'b1;
         ST_WAIT:  cmd.load = 1'b1;
         ST_MIX:   cmd.mix = 1'b1;
         ST_SUM:   cmd.sum = 1'b1;
         ST_OUT:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

`ifndef ASSERT_OFF
   a_no_out_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid && req_stall)
      else $error("output during clear");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_take_then_hash: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> state_ff == ST_HASH)
      else $error("accepted word not processed");
`endif
endmodule

### sv/fgs_dp.sv
module fgs_dp
   import fgs_pkg::*;
#(
   parameter int STORE_DEPTH = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    req_channel,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                    req_freeze,
   input  logic [15:0]             entropy,
   input  logic [15:0]             rot_depth,
   input  logic [16:0]             wet_mix,
   input  logic [15:0]             grain_length,
   input  logic [19:0]             severity_step,
   input  logic [1:0]              num_channels,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);
   localparam int AW = $clog2(STORE_DEPTH);
   localparam int SB = SAMPLE_BITS;
   localparam int JSHIFT = 20 - AW;

   logic [AW:0]   clr_ff;
   logic [AW-1:0] wpos_ff, rpos_ff;
   logic          was_ff;
   logic [31:0]   fcount_ff;
   logic [16:0]   gtimer_ff;
   logic [4:0]    hcnt_ff;
   logic signed [SB-1:0] heldl_ff, heldr_ff, x_ff, out_ff;
   logic          ch_ff, frz_ff, jump_ff, reload_ff;
   logic [31:0]   h_ff;
   logic [18:0]   q_ff;
   logic [13:0]   r_ff;
   logic [29:0]   p_ff;
   logic [32:0]   sev_ff;
   logic [15:0]   rot_ff;
   logic [AW-1:0] jump_amt_ff;
   logic signed [SB+17:0] pa_ff, pb_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [2*SB-1:0] wr_data, rd_data;

   assign status.clear_done = clr_ff[AW];
   assign status.frozen = frz_ff;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = wpos_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en = !clr_ff[AW];
         wr_addr = clr_ff[AW-1:0];
      end else if (cmd.hash && !frz_ff) begin
         // no separate read needed: other lane kept by rd_data from the read in take
         wr_en = 1'b1;
         wr_data = ch_ff ? {x_ff, rd_data[SB-1:0]} : {rd_data[2*SB-1:SB], x_ff};
      end
   end

   fgs_ram #(.WIDTH(2*SB), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(cmd.take ? wpos_ff : rpos_ff), .rd_data(rd_data));

   // jump: r * entropy * DEPTH / 2^20 / 625, the last step by reciprocal
   logic [29:0] jump_y;
   logic [63:0] jump_full;
   assign jump_y = p_ff >> JSHIFT;
   assign jump_full = (64'(jump_y) * 64'(RECIP_10K)) >> 41;

   logic [31:0] hash_v;
   assign hash_v = mixhash(fcount_ff + 32'(wpos_ff));

   logic [4:0]  hold_len;
   logic [3:0]  drop_raw;
   logic [20:0] rot20;
   logic [19:0] rot14;
   assign rot20 = rot_ff * 5'd20;
   assign hold_len = 5'd1 + 5'(rot20 >> 16);
   assign rot14 = rot_ff * 4'd14;

   logic signed [SB-1:0] wet;
   always_comb begin
      logic signed [SB-1:0] v;
      int drop;
      logic [SB-1:0] mask;
      v = ch_ff ? heldr_ff : heldl_ff;
      drop = int'((rot14 + 20'd65535) >> 16) - 1 + (SB - 16);
      if (drop > SB - 1) drop = SB - 1;
      mask = (SB'(1) << drop) - SB'(1);
      wet = v;
      if (rot_ff >= 16'(ROT_MASK_MIN) && drop > 0) wet = v & ~mask;
   end

   logic [16:0] m;
   assign m = (wet_mix > 17'd65536) ? 17'd65536 : wet_mix;
   logic signed [SB+18:0] total;
   logic signed [SB+2:0] res;
   assign total = (SB+19)'(pa_ff) + (SB+19)'(pb_ff) + (SB+19)'(32768);
   assign res = (SB+3)'(total >>> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         wpos_ff <= '0;
         rpos_ff <= '0;
         was_ff <= 1'b0;
         fcount_ff <= '0;
         gtimer_ff <= '0;
         hcnt_ff <= '0;
         heldl_ff <= '0;
         heldr_ff <= '0;
         frz_ff <= 1'b0;
      end else begin
         if (cmd.clear_step && !clr_ff[AW]) clr_ff <= clr_ff + 1'b1;
         if (cmd.take) begin
            ch_ff <= req_channel;
            x_ff <= req_sample_in;
            frz_ff <= req_freeze;
            jump_ff <= 1'b0;
            if (!req_channel) begin
               was_ff <= req_freeze;
               if (req_freeze != was_ff) fcount_ff <= req_freeze ? 32'd1 : 32'd0;
               else if (req_freeze) fcount_ff <= fcount_ff + 1'b1;
               if (req_freeze) begin
                  gtimer_ff <= gtimer_ff + 1'b1;
                  hcnt_ff <= hcnt_ff + 1'b1;
                  jump_ff <= (gtimer_ff + 17'd1) > {1'b0, grain_length};
               end
            end
            out_ff <= req_sample_in;
         end
         if (cmd.hash) begin
            h_ff <= hash_v;
            if (!frz_ff && ch_ff == 1'((num_channels - 2'd1)) &&
                (num_channels - 2'd1) <= 2'd1)
               wpos_ff <= wpos_ff + 1'b1;
         end
         if (cmd.quot) q_ff <= 19'((64'(h_ff) * 64'(RECIP_10K)) >> 45);
         if (cmd.rem) r_ff <= 14'(33'(h_ff) - 33'(q_ff) * 33'(JUMP_RANGE));
         if (cmd.scale) p_ff <= r_ff * entropy;
         if (cmd.sev) begin
            sev_ff <= (fcount_ff * severity_step > 52'h100000000) ?
                      33'h100000000 : 33'(52'(fcount_ff) * 52'(severity_step));
            jump_amt_ff <= AW'(jump_full);
         end
         if (cmd.rot) begin
            rot_ff <= 16'((49'(rot_depth) * 49'(sev_ff)) >> 32);
            if (!ch_ff) begin
               if (jump_ff) begin
                  gtimer_ff <= '0;
                  rpos_ff <= wpos_ff - jump_amt_ff + 1'b1;
               end else begin
                  rpos_ff <= rpos_ff + 1'b1;
               end
            end
         end
         if (cmd.read) reload_ff <= hcnt_ff >= hold_len;
         if (cmd.load && reload_ff) begin
            heldl_ff <= rd_data[SB-1:0];
            heldr_ff <= rd_data[2*SB-1:SB];
            if (!ch_ff) hcnt_ff <= '0;
         end
         if (cmd.mix) begin
            pa_ff <= x_ff * $signed({1'b0, 17'd65536 - m});
            pb_ff <= wet * $signed({1'b0, m});
         end
         if (cmd.sum) begin
            if (res > (SB+3)'((1 << (SB-1)) - 1)) out_ff <= SB'((1 << (SB-1)) - 1);
            else if (res < -(SB+3)'(1 << (SB-1))) out_ff <= SB'(1 << (SB-1));
            else out_ff <= SB'(res);
         end
      end
   end

   assign rsp_sample_out = out_ff;

`ifndef ASSERT_OFF
   a_wpos_frozen: assert property (@(posedge clock) disable iff (reset)
      cmd.hash && frz_ff |=> $stable(wpos_ff))
      else $error("write position moved while frozen");
   a_no_write_frozen: assert property (@(posedge clock) disable iff (reset)
      wr_en && !cmd.clear_step |-> !frz_ff)
      else $error("store written while frozen");
   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> hold_len >= 5'd1 && hold_len <= 5'd21)
      else $error("hold length out of range");
`endif
endmodule

### sv/freeze_glitch_sampler_unit.sv
// channel | valid     | stall     | payload
// req     | req_valid | req_stall | req_channel, req_sample_in, req_freeze
// rsp     | rsp_valid | rsp_stall | rsp_sample_out
// One word at a time, plus output stall; a frozen word runs the full state sequence.
// The frozen path does the jump division by reciprocal in its QUOT, REM and SEV states.
// The stored word is read, merged and written back through the store's separate read and write ports.
// After reset a clearing pass zeroes every word of the store; no word
// is taken then. Reset is synchronous; a stalled result holds.
module freeze_glitch_sampler_unit
   import fgs_pkg::*;
#(
   parameter int STORE_DEPTH = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_channel,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic req_freeze,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);
   logic [15:0] entropy_ff, rot_ff, grain_ff;
   logic [16:0] wet_ff;
   logic [19:0] step_ff;
   logic [1:0]  nch_ff;
   cmd_type     cmd;
   status_type  status;

   always_ff @(posedge clock) begin
      if (reset) begin
         entropy_ff <= '0;
         rot_ff <= '0;
         wet_ff <= 17'd32768;
         grain_ff <= 16'd2205;
         step_ff <= 20'd19478;
         nch_ff <= 2'd2;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ENTROPY:  entropy_ff <= csr_data[15:0];
            CSR_ROT:      rot_ff <= csr_data[15:0];
            CSR_WET:      wet_ff <= csr_data[16:0];
            CSR_GRAIN:    grain_ff <= csr_data[15:0];
            CSR_SEVSTEP:  step_ff <= csr_data[19:0];
            CSR_CHANNELS: nch_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   fgs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .cmd(cmd));

   fgs_dp #(.STORE_DEPTH(STORE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_channel(req_channel), .req_sample_in(req_sample_in),
      .req_freeze(req_freeze), .entropy(entropy_ff), .rot_depth(rot_ff),
      .wet_mix(wet_ff), .grain_length(grain_ff), .severity_step(step_ff),
      .num_channels(nch_ff), .rsp_sample_out(rsp_sample_out));
endmodule

### tb/freeze_glitch_sampler_unit_tb.sv
`timescale 1ns / 1ps

module freeze_glitch_sampler_unit_tb;
   import fgs_pkg::*;

   localparam int DEPTH = 65536;
   localparam int WATCHDOG_LIMIT = 200000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_channel;
   logic signed [15:0] req_sample_in;
   logic req_freeze;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_sample_out;
   logic csr_write;
   logic [2:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   freeze_glitch_sampler_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_channel(req_channel), .req_sample_in(req_sample_in),
      .req_freeze(req_freeze),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // effect state mirror
   logic signed [15:0] store_l [DEPTH];
   logic signed [15:0] store_r [DEPTH];
   logic [15:0] wr_pos, rd_pos;
   logic        frz_prev;
   logic [31:0] frz_count;
   logic [16:0] grain_tmr;
   logic [4:0]  hold_cnt;
   logic signed [15:0] held_l, held_r;
   logic [15:0] entropy_r, rot_depth_r, grain_len_r;
   logic [16:0] wet_r;
   logic [19:0] sev_step_r;
   logic [1:0]  nch_r;

   logic signed [15:0] sample_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 0;

   typedef struct {
      logic ch;
      logic signed [15:0] x;
      logic frz;
      bit has_exp;
      logic signed [15:0] exp_out;
   } row_type;

   row_type rows[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [15:0] floor_bits(logic signed [15:0] v, logic [15:0] rot);
      int drop;
      logic [15:0] mask;
      if (rot < 16'd3277) return v;
      drop = int'((32'(rot) * 14 + 65535) >> 16) - 1;
      if (drop <= 0) return v;
      if (drop > 15) drop = 15;
      mask = 16'((32'd1 << drop) - 1);
      return v & ~mask;
   endfunction

   function automatic logic [31:0] shift_xor(logic [31:0] s_in);
      logic [31:0] s;
      s = (s_in ^ 32'd61) ^ (s_in >> 16);
      s = s + (s << 3);
      s = s ^ (s >> 4);
      return s;
   endfunction

   function automatic logic signed [15:0] predict_sample(logic ch, logic signed [15:0] x,
                                                          logic frz);
      logic [63:0] sev, jump;
      logic [31:0] r;
      logic [15:0] rot;
      logic [31:0] hold;
      logic [16:0] m;
      logic signed [15:0] wet;
      longint acc, res;
      if (ch == 1'b0) begin
         if (frz != frz_prev) frz_count = 0;
         frz_prev = frz;
         if (frz) frz_count = frz_count + 1;
      end
      if (!frz) begin
         if (ch) store_r[wr_pos] = x;
         else store_l[wr_pos] = x;
         if ({1'b0, ch} == 2'(nch_r - 2'd1)) wr_pos = wr_pos + 16'd1;
         return x;
      end
      if (ch == 1'b0) begin
         grain_tmr = grain_tmr + 17'd1;
         if (grain_tmr > {1'b0, grain_len_r}) begin
            r = shift_xor(frz_count + 32'(wr_pos)) % 10000;
            jump = (64'(r) * 64'(entropy_r) * 64'(DEPTH)) / (64'd10000 * 64'd65536);
            grain_tmr = 0;
            rd_pos = wr_pos - 16'(jump);
         end
         rd_pos = rd_pos + 16'd1;
      end
      sev = 64'(frz_count) * 64'(sev_step_r);
      if (sev > 64'h1_0000_0000) sev = 64'h1_0000_0000;
      rot = 16'((64'(rot_depth_r) * sev) >> 32);
      hold = 1 + ((32'(rot) * 20) >> 16);
      if (ch == 1'b0) hold_cnt = hold_cnt + 5'd1;
      if (32'(hold_cnt) >= hold) begin
         held_l = store_l[rd_pos];
         held_r = store_r[rd_pos];
         if (ch == 1'b0) hold_cnt = 0;
      end
      wet = floor_bits(ch ? held_r : held_l, rot);
      m = (wet_r > 17'd65536) ? 17'd65536 : wet_r;
      acc = longint'(x) * longint'(65536 - int'(m)) + longint'(wet) * longint'(m);
      res = (acc + 32768) >>> 16;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return 16'(res);
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [19:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ENTROPY:  entropy_r = val[15:0];
         CSR_ROT:      rot_depth_r = val[15:0];
         CSR_WET:      wet_r = val[16:0];
         CSR_GRAIN:    grain_len_r = val[15:0];
         CSR_SEVSTEP:  sev_step_r = val;
         CSR_CHANNELS: nch_r = val[1:0];
         default: ;
      endcase
   endtask

   // hold valid through stall; predict on acceptance
   task automatic send_sample(logic ch, logic signed [15:0] x, logic frz, bit has_exp,
                              logic signed [15:0] exp_out);
      logic signed [15:0] p;
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= ch;
      req_sample_in <= x;
      req_freeze <= frz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_sample(ch, x, frz);
      if (has_exp && p !== exp_out) begin
         errors++;
         if (errors <= 10)
            $display("table row mismatch: table %0d predictor %0d", exp_out, p);
      end
      sample_q.push_back(p);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sample_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // receiver: random stall bursts
   initial begin
      int burst;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      logic signed [15:0] e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word: sample_out %0d", rsp_sample_out);
         end else begin
            e = sample_q.pop_front();
            if (rsp_sample_out !== e) begin
               errors++;
               if (errors <= 10)
                  $display("sample_out mismatch: expected %0d actual %0d", e, rsp_sample_out);
            end
         end
      end
   end

   // count cycles with nothing accepted
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("freeze_glitch_sampler_unit_tb: done, errors");
         $finish;
      end
   end

   task automatic run_frames(int frames, int freeze_pct, bit both_ch);
      logic frz;
      logic signed [15:0] x;
      for (int f = 0; f < frames; f++) begin
         frz = ($urandom_range(0, 99) < freeze_pct);
         if ($urandom_range(0, 40) == 0) frz = ~frz;
         x = 16'($urandom);
         send_sample(1'b0, x, frz, 0, 0);
         if (both_ch || $urandom_range(0, 3) == 0) begin
            x = 16'($urandom);
            send_sample(1'b1, x, frz, 0, 0);
         end
      end
   endtask

   initial begin
      int frozen_run;
      req_valid = 0; req_channel = 0; req_sample_in = 0; req_freeze = 0;
      csr_write = 0; csr_index = CSR_ENTROPY; csr_data = 0;
      reset = 1;
      for (int i = 0; i < DEPTH; i++) begin
         store_l[i] = 0;
         store_r[i] = 0;
      end
      wr_pos = 0; rd_pos = 0; frz_prev = 0; frz_count = 0; grain_tmr = 0;
      hold_cnt = 0; held_l = 0; held_r = 0;
      entropy_r = 0; rot_depth_r = 0; wet_r = 17'd32768; grain_len_r = 16'd2205;
      sev_step_r = 20'd19478; nch_r = 2'd2;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pass-through extremes, then frozen reads at reset settings, then pass-through again
      rows = '{
         '{1'b0, 16'sh7FFF, 1'b0, 1, 16'sh7FFF},
         '{1'b1, 16'sh8000, 1'b0, 1, 16'sh8000},
         '{1'b0, 16'sh0000, 1'b0, 1, 16'sh0000},
         '{1'b1, 16'shFFFF, 1'b0, 1, 16'shFFFF},
         '{1'b0, 16'sh5555, 1'b0, 1, 16'sh5555},
         '{1'b1, 16'shAAAA, 1'b0, 1, 16'shAAAA},
         '{1'b0, 16'sh7FFF, 1'b1, 0, 0},
         '{1'b1, 16'sh8000, 1'b1, 0, 0},
         '{1'b0, 16'sh8000, 1'b1, 0, 0},
         '{1'b1, 16'sh7FFF, 1'b1, 0, 0},
         '{1'b1, 16'sh1234, 1'b0, 1, 16'sh1234},
         '{1'b0, 16'sh4321, 1'b0, 1, 16'sh4321}
      };
      foreach (rows[i])
         send_sample(rows[i].ch, rows[i].x, rows[i].frz, rows[i].has_exp, rows[i].exp_out);
      drain_results();

      // all wet, fast severity, zero grain length: jump on every frozen left word
      write_csr(CSR_WET, 20'd65536);
      write_csr(CSR_ENTROPY, 20'd65535);
      write_csr(CSR_ROT, 20'd65535);
      write_csr(CSR_GRAIN, 20'd0);
      write_csr(CSR_SEVSTEP, 20'hFFFFF);
      run_frames(60, 70, 1);
      drain_results();

      // mix saturation and a mono layout
      write_csr(CSR_WET, 20'h1FFFF);
      write_csr(CSR_CHANNELS, 20'd1);
      write_csr(CSR_GRAIN, 20'd3);
      run_frames(50, 50, 0);
      drain_results();

      // bad channel counts stall the write position
      write_csr(CSR_CHANNELS, 20'd0);
      run_frames(20, 40, 1);
      drain_results();
      write_csr(CSR_CHANNELS, 20'd3);
      run_frames(20, 40, 1);
      drain_results();

      // random phases: long frozen runs with random content
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_ENTROPY, 20'($urandom_range(0, 65535)));
         write_csr(CSR_ROT, 20'($urandom_range(0, 65535)));
         write_csr(CSR_WET, 20'($urandom_range(0, 65536)));
         write_csr(CSR_GRAIN, 20'($urandom_range(1, 20)));
         write_csr(CSR_SEVSTEP, 20'($urandom_range(1, 1048575)));
         write_csr(CSR_CHANNELS, (ph == 3) ? 20'd1 : 20'd2);
         if (ph == 7) quiet = 1;
         // fill some history, then freeze for a while
         run_frames(20, 0, 1);
         frozen_run = $urandom_range(40, 70);
         run_frames(frozen_run, 95, 1);
         drain_results();
      end

      // wait for full drain before ending
      drain_results();
      if (errors == 0)
         $display("freeze_glitch_sampler_unit_tb: done, clean");
      else
         $display("freeze_glitch_sampler_unit_tb: done, errors");
      $finish;
   end

endmodule

### files.f
sv/fgs_pkg.sv
sv/fgs_ram.sv
sv/fgs_ctrl.sv
sv/fgs_dp.sv
sv/freeze_glitch_sampler_unit.sv
tb/freeze_glitch_sampler_unit_tb.sv
